>>> sv/gifl_pkg.sv
// Types and constants used by the GIF LZW decoder core and its testbench.
// Holds the transaction payloads, command and status codes and the controller states.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gifl_pkg;

	localparam int DICT_DEPTH = 4096;
	localparam int DICT_AW = 12;
	localparam logic [11:0] LAST_CODE = 12'd4095;
	localparam logic [3:0] MAX_WIDTH = 4'd12;
	localparam logic [11:0] ENTRY_MASK = 12'h0FFF;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PUSH = 2'd1,
		CMD_PULL = 2'd2,
		CMD_NONE = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		ST_STARTED = 3'd0,
		ST_TAKEN = 3'd1,
		ST_REFUSED = 3'd2,
		ST_PIXEL = 3'd3,
		ST_NEED = 3'd4,
		ST_CLEARED = 3'd5,
		ST_FINISHED = 3'd6,
		ST_ERROR = 3'd7
	} status_e;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SIZE = 2'd1,
		PH_DECODE = 2'd2,
		PH_DRAIN = 2'd3
	} phase_e;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_POP = 2'd1,
		FSM_WALK = 2'd2,
		FSM_FETCH = 2'd3
	} fsm_e;

	localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_INTERLACED = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] pixel_index;
		logic [15:0] row;
		logic [15:0] column;
		logic [15:0] bad_code_total;
	} out_t;

	// First row and row step of each interlace pass.
	function automatic logic [3:0] pass_start(input logic [1:0] p);
		case (p)
			2'd0: pass_start = 4'd0;
			2'd1: pass_start = 4'd4;
			2'd2: pass_start = 4'd2;
			default: pass_start = 4'd1;
		endcase
	endfunction

	function automatic logic [3:0] pass_step(input logic [1:0] p);
		case (p)
			2'd0: pass_step = 4'd8;
			2'd1: pass_step = 4'd8;
			2'd2: pass_step = 4'd4;
			default: pass_step = 4'd2;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> sv/gifl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the prefix, suffix and pixel stack stores; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gifl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> sv/gif_lzw_decoder_core.sv
// Top level of the GIF LZW decoder: controller, bit buffer, dictionary and pixel stack.
// Depends on gifl_pkg and gifl_ram.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction (start, push byte or pull pixel) yields exactly one result
// transaction. Start and push are answered straight from the idle state into the result
// register. A pull served from the pixel stack passes through the pop state, as the stack
// memory has a registered read port. A pull that decodes a new code alternates walk and
// fetch states along the prefix chain: each step reads the prefix and suffix tables and
// then writes the pixel stack. The next transaction is taken once the result has left.
module gif_lzw_decoder_core
	import gifl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);

	fsm_e state_q, state_d;
	phase_e phase_q, phase_d;
	logic [15:0] width_q, height_q;
	logic interlaced_q;
	logic [12:0] count_q, count_d;
	logic [19:0] bbuf_q, bbuf_d;
	logic [4:0] bcnt_q, bcnt_d;
	logic [7:0] bbl_q, bbl_d;
	logic [3:0] min_q, min_d, cw_q, cw_d;
	logic [12:0] slot_q, slot_d, limit_q, limit_d;
	logic [11:0] old_q, old_d, wcode_q, wcode_d, incode_q, incode_d;
	logic [7:0] first_q, first_d;
	logic aclr_q, aclr_d;
	logic [15:0] row_q, row_d, col_q, col_d, bad_q, bad_d;
	logic [1:0] pass_q, pass_d;
	logic out_valid_q, out_valid_d;
	out_t out_q, out_d;

	// Memory ports
	logic stk_we, tbl_we;
	logic [11:0] stk_waddr, stk_raddr, tbl_waddr, tbl_raddr;
	logic [7:0] stk_wdata, stk_rdata, suf_wdata, suf_rdata;
	logic [11:0] pre_wdata, pre_rdata;

	gifl_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);
	gifl_ram #(.WIDTH(12), .DEPTH(DICT_DEPTH)) u_prefix (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(pre_wdata),
		.raddr(tbl_raddr), .rdata(pre_rdata)
	);
	gifl_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_suffix (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(suf_wdata),
		.raddr(tbl_raddr), .rdata(suf_rdata)
	);

	// Position of the next pixel: error check, column wrap and next row.
	logic em_err, col_wrap;
	logic [16:0] nr;
	logic [1:0] np;
	logic [15:0] row_next;

	always_comb begin
		em_err = row_q >= height_q;
		col_wrap = ({1'b0, col_q} + 17'd1) >= {1'b0, width_q};
		np = pass_q;
		if (!interlaced_q) begin
			nr = {1'b0, row_q} + 17'd1;
		end else begin
			nr = {1'b0, row_q} + {13'd0, pass_step(pass_q)};
			for (int i = 0; i < 3; i++) begin
				if (np != 2'd3 && nr >= {1'b0, height_q}) begin
					np = np + 2'd1;
					nr = {13'd0, pass_start(np)};
				end
			end
		end
		row_next = nr[16] ? 16'hFFFF : nr[15:0];
	end

	// Code extraction from the bit buffer.
	logic [19:0] cmask;
	logic [11:0] code;
	logic [12:0] clear_code, tbl_slot;
	logic [7:0] v;

	always_comb begin
		cmask = (20'd1 << cw_q) - 20'd1;
		code = 12'(bbuf_q & cmask) & ENTRY_MASK;
		clear_code = 13'd1 << min_q;
		v = in_data.data_byte;
	end

	assign in_ready = (state_q == FSM_IDLE) && !out_valid_q;

	// Controller: next state, state updates and result.
	logic emit_en, fin_err;
	logic [7:0] emit_px;
	logic [2:0] res_st;

	always_comb begin
		state_d = state_q; phase_d = phase_q; count_d = count_q; bbuf_d = bbuf_q;
		bcnt_d = bcnt_q; bbl_d = bbl_q; min_d = min_q; cw_d = cw_q; slot_d = slot_q;
		limit_d = limit_q; old_d = old_q; wcode_d = wcode_q; incode_d = incode_q;
		first_d = first_q; aclr_d = aclr_q; row_d = row_q; col_d = col_q; bad_d = bad_q;
		pass_d = pass_q;
		out_valid_d = out_valid_q && !out_ready;
		out_d = out_q;
		stk_we = 1'b0; stk_waddr = count_q[11:0]; stk_wdata = 8'd0;
		stk_raddr = 12'(count_q - 13'd1);
		tbl_we = 1'b0; tbl_waddr = slot_q[11:0]; pre_wdata = old_q; suf_wdata = 8'd0;
		tbl_raddr = wcode_q;
		tbl_slot = slot_q;
		emit_en = 1'b0; emit_px = 8'd0; fin_err = 1'b0;
		res_st = ST_REFUSED;

		case (state_q)
			FSM_IDLE: begin
				if (in_valid && in_ready) begin
					out_valid_d = 1'b1;
					case (in_data.command)
						CMD_START: begin
							count_d = '0; bbuf_d = '0; bcnt_d = '0; bbl_d = '0; min_d = '0;
							cw_d = '0; slot_d = '0; limit_d = '0; old_d = '0; first_d = '0;
							aclr_d = 1'b0; row_d = '0; col_d = '0; pass_d = '0; bad_d = '0;
							phase_d = PH_SIZE;
							res_st = ST_STARTED;
						end
						CMD_PUSH: begin
							if (phase_q == PH_SIZE) begin
								if (v < 8'd2 || v > 8'd9) begin
									phase_d = PH_IDLE;
									res_st = ST_ERROR;
								end else begin
									min_d = v[3:0];
									cw_d = v[3:0] + 4'd1;
									limit_d = 13'd1 << (v[3:0] + 4'd1);
									slot_d = (13'd1 << v[3:0]) + 13'd2;
									aclr_d = 1'b1;
									phase_d = PH_DECODE;
									res_st = ST_TAKEN;
								end
							end else if (phase_q != PH_DECODE) begin
								res_st = ST_REFUSED;
							end else if (bbl_q == 8'd0) begin
								if (v == 8'd0) begin
									phase_d = PH_DRAIN;
								end else begin
									bbl_d = v;
								end
								res_st = ST_TAKEN;
							end else if (bcnt_q > 5'd12) begin
								res_st = ST_REFUSED;
							end else begin
								bbuf_d = bbuf_q | (20'(v) << bcnt_q);
								bcnt_d = bcnt_q + 5'd8;
								bbl_d = bbl_q - 8'd1;
								res_st = ST_TAKEN;
							end
						end
						CMD_PULL: begin
							if (phase_q == PH_IDLE) begin
								res_st = ST_FINISHED;
							end else if (phase_q == PH_SIZE) begin
								res_st = ST_NEED;
							end else if (count_q != 13'd0) begin
								// Pop from the stack; the pixel arrives next cycle.
								count_d = count_q - 13'd1;
								out_valid_d = 1'b0;
								state_d = FSM_POP;
							end else if (bcnt_q < {1'b0, cw_q}) begin
								if (phase_q == PH_DRAIN) begin
									phase_d = PH_IDLE;
									res_st = ST_FINISHED;
								end else begin
									res_st = ST_NEED;
								end
							end else begin
								bbuf_d = bbuf_q >> cw_q;
								bcnt_d = bcnt_q - {1'b0, cw_q};
								if ({1'b0, code} == clear_code) begin
									cw_d = min_q + 4'd1;
									limit_d = 13'd1 << (min_q + 4'd1);
									slot_d = clear_code + 13'd2;
									aclr_d = 1'b1;
									res_st = ST_CLEARED;
								end else if ({1'b0, code} == clear_code + 13'd1) begin
									phase_d = PH_IDLE;
									res_st = ST_FINISHED;
								end else if (aclr_q) begin
									old_d = ({1'b0, code} >= slot_q) ? 12'd0 : code;
									first_d = ({1'b0, code} >= slot_q) ? 8'd0 : code[7:0];
									aclr_d = 1'b0;
									emit_en = 1'b1;
									emit_px = ({1'b0, code} >= slot_q) ? 8'd0 : code[7:0];
								end else begin
									incode_d = code;
									wcode_d = code;
									out_valid_d = 1'b0;
									state_d = FSM_WALK;
									if ({1'b0, code} >= slot_q) begin
										if ({1'b0, code} > slot_q && bad_q != 16'hFFFF) begin
											bad_d = bad_q + 16'd1;
										end
										stk_we = 1'b1;
										stk_wdata = first_q;
										count_d = count_q + 13'd1;
										wcode_d = old_q;
									end
								end
							end
						end
						default: res_st = ST_REFUSED;
					endcase
				end
			end
			FSM_POP: begin
				out_valid_d = 1'b1;
				emit_en = 1'b1;
				emit_px = stk_rdata;
				state_d = FSM_IDLE;
			end
			FSM_WALK: begin
				if (count_q[12]) begin
					fin_err = 1'b1;
				end else if ({1'b0, wcode_q} >= clear_code + 13'd2) begin
					tbl_raddr = wcode_q;
					state_d = FSM_FETCH;
				end else begin
					// Chain root: it is pushed and popped at once, so emit it directly.
					first_d = wcode_q[7:0];
					tbl_slot = slot_q;
					if (slot_q < limit_q && slot_q <= {1'b0, LAST_CODE}) begin
						tbl_we = 1'b1;
						suf_wdata = wcode_q[7:0];
						tbl_slot = slot_q + 13'd1;
						slot_d = tbl_slot;
					end
					if (tbl_slot >= limit_q && cw_q < MAX_WIDTH) begin
						limit_d = limit_q << 1;
						cw_d = cw_q + 4'd1;
					end
					old_d = incode_q;
					out_valid_d = 1'b1;
					emit_en = 1'b1;
					emit_px = wcode_q[7:0];
					state_d = FSM_IDLE;
				end
			end
			FSM_FETCH: begin
				stk_we = 1'b1;
				stk_wdata = suf_rdata;
				count_d = count_q + 13'd1;
				wcode_d = pre_rdata & ENTRY_MASK;
				state_d = FSM_WALK;
			end
			default: state_d = FSM_IDLE;
		endcase

		// Stack overflow
		if (fin_err) begin
			phase_d = PH_IDLE;
			count_d = '0;
			out_valid_d = 1'b1;
			res_st = ST_ERROR;
			state_d = FSM_IDLE;
		end

		out_d = '0;
		if (emit_en) begin
			if (em_err) begin
				phase_d = PH_IDLE;
				count_d = '0;
				res_st = ST_ERROR;
			end else begin
				res_st = ST_PIXEL;
				out_d.pixel_index = emit_px;
				out_d.row = row_q;
				out_d.column = col_q;
				if (col_wrap) begin
					col_d = '0;
					row_d = row_next;
					pass_d = np;
				end else begin
					col_d = col_q + 16'd1;
				end
			end
		end
		out_d.status = res_st;
		out_d.bad_code_total = bad_d;
		if (!(out_valid_d && !out_valid_q)) begin
			out_d = out_q;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 16'd1;
			height_q <= 16'd1;
			interlaced_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_INTERLACED: interlaced_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Controller and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE; phase_q <= PH_IDLE; count_q <= '0; bbuf_q <= '0;
			bcnt_q <= '0; bbl_q <= '0; min_q <= '0; cw_q <= '0; slot_q <= '0;
			limit_q <= '0; old_q <= '0; wcode_q <= '0; incode_q <= '0; first_q <= '0;
			aclr_q <= 1'b0; row_q <= '0; col_q <= '0; bad_q <= '0; pass_q <= '0;
			out_valid_q <= 1'b0; out_q <= '0;
		end else begin
			state_q <= state_d; phase_q <= phase_d; count_q <= count_d; bbuf_q <= bbuf_d;
			bcnt_q <= bcnt_d; bbl_q <= bbl_d; min_q <= min_d; cw_q <= cw_d; slot_q <= slot_d;
			limit_q <= limit_d; old_q <= old_d; wcode_q <= wcode_d; incode_q <= incode_d;
			first_q <= first_d; aclr_q <= aclr_d; row_q <= row_d; col_q <= col_d;
			bad_q <= bad_d; pass_q <= pass_d;
			out_valid_q <= out_valid_d; out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The stack never holds more than the dictionary depth.
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 13'(DICT_DEPTH)) else $error("stack count beyond depth");
	// A table fetch always follows a walk step.
	a_fetch_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_FETCH |-> $past(state_q) == FSM_WALK)
		else $error("fetch without walk step");
	// Code width stays within twelve bits.
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		cw_q <= MAX_WIDTH) else $error("code width too large");
	// No new transaction and no waiting result while the decoder is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != FSM_IDLE |-> !in_ready && !out_valid_q)
		else $error("accepting while busy");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the GIF LZW decoder core.
// Drives image streams, predicts every result transaction and compares each whole result.
// Depends on gifl_pkg and gif_lzw_decoder_core.
`timescale 1ns / 1ps
module tb_top;
	import gifl_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	gif_lzw_decoder_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the decoder configuration and state.
	logic [15:0] cfg_width = 16'd1, cfg_height = 16'd1;
	logic cfg_ilace = 1'b0;
	logic [11:0] pre_tab [DICT_DEPTH];
	logic [7:0] suf_tab [DICT_DEPTH];
	logic [7:0] px_stack [DICT_DEPTH];
	logic [12:0] stk_cnt, nxt_slot, slot_lim;
	logic [19:0] bit_buf;
	logic [4:0] bit_cnt;
	logic [7:0] blk_left, first_px;
	logic [3:0] min_sz, code_w;
	logic [11:0] prev_code;
	logic fresh_table;
	phase_e dec_phase = PH_IDLE;
	logic [15:0] row_pos, col_pos, bad_cnt;
	logic [1:0] ilace_pass;

	out_t pending_q [$];
	out_t want;
	logic [7:0] stream_q [$];
	int forced_q [$];
	int send_idle = 0, recv_stall = 0, hold_left = 0;
	int items = 0, pixels = 0, images = 0, results = 0, fails = 0;

	function automatic out_t result(status_e st, logic [7:0] px, logic [15:0] r, logic [15:0] c);
		out_t o;
		o.status = st;
		o.pixel_index = px;
		o.row = r;
		o.column = c;
		o.bad_code_total = bad_cnt;
		return o;
	endfunction

	function automatic void clear_decoder();
		stk_cnt = '0; bit_buf = '0; bit_cnt = '0; blk_left = '0; min_sz = '0;
		code_w = '0; nxt_slot = '0; slot_lim = '0; prev_code = '0; first_px = '0;
		fresh_table = 1'b0; row_pos = '0; col_pos = '0; ilace_pass = '0; bad_cnt = '0;
	endfunction

	function automatic void reset_dict();
		code_w = min_sz + 4'd1;
		slot_lim = 13'(1 << code_w);
		nxt_slot = 13'((1 << min_sz) + 2);
		fresh_table = 1'b1;
	endfunction

	function automatic out_t abort_error();
		dec_phase = PH_IDLE;
		stk_cnt = '0;
		return result(ST_ERROR, 8'd0, 16'd0, 16'd0);
	endfunction

	// Row order: sequential, or the four interlace passes with empty passes skipped.
	function automatic void advance_row();
		int unsigned r;
		if (!cfg_ilace) begin
			r = row_pos + 1;
		end else begin
			r = row_pos + ((ilace_pass == 2'd3) ? 2 : (ilace_pass == 2'd2) ? 4 : 8);
			while (ilace_pass < 2'd3 && r >= cfg_height) begin
				ilace_pass++;
				r = (ilace_pass == 2'd1) ? 4 : (ilace_pass == 2'd2) ? 2 : 1;
			end
		end
		row_pos = (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic out_t emit_px(logic [7:0] px);
		logic [15:0] r, c;
		if (row_pos >= cfg_height)
			return abort_error();
		r = row_pos;
		c = col_pos;
		if (32'(col_pos) + 1 >= 32'(cfg_width)) begin
			col_pos = '0;
			advance_row();
		end else begin
			col_pos++;
		end
		return result(ST_PIXEL, px, r, c);
	endfunction

	function automatic bit stack_push(logic [7:0] px);
		if (stk_cnt >= DICT_DEPTH)
			return 1'b0;
		px_stack[stk_cnt[11:0]] = px;
		stk_cnt++;
		return 1'b1;
	endfunction

	// A pull: pop the stack, or take the next code and expand it.
	function automatic out_t pull_pixel();
		logic [11:0] code, incode, clr;
		if (dec_phase == PH_IDLE)
			return result(ST_FINISHED, 8'd0, 16'd0, 16'd0);
		if (dec_phase == PH_SIZE)
			return result(ST_NEED, 8'd0, 16'd0, 16'd0);
		if (stk_cnt > 0) begin
			stk_cnt--;
			return emit_px(px_stack[stk_cnt[11:0]]);
		end
		if (bit_cnt < code_w) begin
			if (dec_phase == PH_DRAIN) begin
				dec_phase = PH_IDLE;
				return result(ST_FINISHED, 8'd0, 16'd0, 16'd0);
			end
			return result(ST_NEED, 8'd0, 16'd0, 16'd0);
		end
		code = 12'(bit_buf & ((20'd1 << code_w) - 20'd1));
		bit_buf = bit_buf >> code_w;
		bit_cnt = bit_cnt - code_w;
		clr = 12'(1 << min_sz);
		if (code == clr) begin
			reset_dict();
			return result(ST_CLEARED, 8'd0, 16'd0, 16'd0);
		end
		if (code == clr + 12'd1) begin
			dec_phase = PH_IDLE;
			return result(ST_FINISHED, 8'd0, 16'd0, 16'd0);
		end
		if (fresh_table) begin
			if (code >= nxt_slot)
				code = '0;
			prev_code = code;
			first_px = code[7:0];
			fresh_table = 1'b0;
			return emit_px(code[7:0]);
		end
		incode = code;
		// A code not yet in the table repeats the previous string plus its first pixel.
		if (code >= nxt_slot) begin
			if (code > nxt_slot && bad_cnt != 16'hFFFF)
				bad_cnt++;
			void'(stack_push(first_px));
			code = prev_code;
		end
		while (code >= clr + 12'd2) begin
			if (!stack_push(suf_tab[code]))
				return abort_error();
			code = pre_tab[code];
		end
		if (!stack_push(code[7:0]))
			return abort_error();
		first_px = code[7:0];
		if (nxt_slot < slot_lim && nxt_slot <= LAST_CODE) begin
			suf_tab[nxt_slot[11:0]] = first_px;
			pre_tab[nxt_slot[11:0]] = prev_code;
			nxt_slot++;
		end
		if (nxt_slot >= slot_lim && code_w < MAX_WIDTH) begin
			slot_lim = slot_lim << 1;
			code_w++;
		end
		prev_code = incode;
		stk_cnt--;
		return emit_px(px_stack[stk_cnt[11:0]]);
	endfunction

	function automatic out_t push_byte(logic [7:0] v);
		if (dec_phase == PH_SIZE) begin
			if (v < 8'd2 || v > 8'd9) begin
				dec_phase = PH_IDLE;
				return result(ST_ERROR, 8'd0, 16'd0, 16'd0);
			end
			min_sz = v[3:0];
			reset_dict();
			dec_phase = PH_DECODE;
			return result(ST_TAKEN, 8'd0, 16'd0, 16'd0);
		end
		if (dec_phase != PH_DECODE)
			return result(ST_REFUSED, 8'd0, 16'd0, 16'd0);
		if (blk_left == 0) begin
			if (v == 0)
				dec_phase = PH_DRAIN;
			else
				blk_left = v;
			return result(ST_TAKEN, 8'd0, 16'd0, 16'd0);
		end
		if (bit_cnt > 5'd12)
			return result(ST_REFUSED, 8'd0, 16'd0, 16'd0);
		bit_buf = bit_buf | (20'(v) << bit_cnt);
		bit_cnt = bit_cnt + 5'd8;
		blk_left--;
		return result(ST_TAKEN, 8'd0, 16'd0, 16'd0);
	endfunction

	function automatic out_t predict_result(cmd_e cmd, logic [7:0] v);
		case (cmd)
			CMD_START: begin
				clear_decoder();
				dec_phase = PH_SIZE;
				return result(ST_STARTED, 8'd0, 16'd0, 16'd0);
			end
			CMD_PUSH: return push_byte(v);
			CMD_PULL: return pull_pixel();
			default: return result(ST_REFUSED, 8'd0, 16'd0, 16'd0);
		endcase
	endfunction

	// Offers one transaction, waits for it to be taken and records what should come back.
	task automatic send(input cmd_e cmd, input logic [7:0] v, input bit typed,
			input out_t fixed, output out_t got);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data.command = cmd;
		in_data.data_byte = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = predict_result(cmd, v);
		pending_q.push_back(typed ? fixed : got);
		items++;
		if (got.status == ST_PIXEL)
			pixels++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LINE_WIDTH: cfg_width = val;
			REG_HEIGHT: cfg_height = val;
			default: cfg_ilace = val[0];
		endcase
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Builds one image stream: code size, sub-blocks of LSB-first codes, terminator.
	// The code width follows the decoder's table growth. A bad code is always followed
	// by a clear or the end, so no table entry is ever read before it is written.
	task automatic build_stream(input int msz, input int n_codes, input bit lit_only);
		int clr, w, nslot, lim, code, i, nb, blk, hi, r, pos;
		bit fresh, prev_bad, done, use_forced;
		longint unsigned acc;
		logic [7:0] packed_q [$];
		clr = 1 << msz; w = msz + 1; lim = 1 << w; nslot = clr + 2;
		fresh = 1'b1; prev_bad = 1'b0; done = 1'b0; acc = 0; nb = 0;
		use_forced = forced_q.size() != 0;
		for (i = 0; !done; i++) begin
			hi = (1 << w) - 1;
			if (use_forced) begin
				code = forced_q.pop_front();
				done = forced_q.size() == 0;
			end else if (i >= n_codes) begin
				done = 1'b1;
				code = ($urandom_range(3) != 0 || prev_bad) ? clr + 1 : -1;
			end else if (prev_bad) begin
				code = clr;
			end else begin
				r = $urandom_range(99);
				if (!lit_only && r < 4)
					code = clr;
				else if (!lit_only && !fresh && r < 8 && nslot < hi)
					code = $urandom_range(nslot + 1, hi);
				else if (fresh && !lit_only)
					code = $urandom_range(0, hi);
				else if (lit_only || r < 50 || nslot <= clr + 2)
					code = $urandom_range(0, clr - 1);
				else if (r < 58 && nslot <= 4095)
					code = nslot;
				else
					code = $urandom_range(clr + 2, nslot - 1);
				if (code == clr + 1)
					code = 0;
			end
			if (code >= 0) begin
				acc = acc | (longint'(code) << nb);
				nb += w;
				while (nb >= 8) begin
					packed_q.push_back(8'(acc));
					acc = acc >> 8;
					nb -= 8;
				end
				prev_bad = 1'b0;
				if (code == clr) begin
					w = msz + 1; lim = 1 << w; nslot = clr + 2; fresh = 1'b1;
				end else if (fresh) begin
					fresh = 1'b0;
				end else if (code != clr + 1) begin
					prev_bad = code > nslot;
					if (nslot < lim && nslot <= 4095)
						nslot++;
					if (nslot >= lim && w < 12) begin
						lim = lim << 1;
						w++;
					end
				end
			end
		end
		if (nb > 0)
			packed_q.push_back(8'(acc));
		stream_q.delete();
		stream_q.push_back(8'(msz));
		pos = 0;
		while (pos < packed_q.size()) begin
			blk = $urandom_range(1, $urandom_range(1) ? 8 : 255);
			if (blk > packed_q.size() - pos)
				blk = packed_q.size() - pos;
			stream_q.push_back(8'(blk));
			repeat (blk) begin
				stream_q.push_back(packed_q[pos]);
				pos++;
			end
		end
		stream_q.push_back(8'd0);
	endtask

	// Decide between pushing the next stream byte and pulling a pixel.
	function automatic bit push_next();
		if (dec_phase == PH_SIZE)
			return 1'b1;
		if (dec_phase != PH_DECODE)
			return 1'b0;
		if (blk_left == 0)
			return 1'($urandom_range(1));
		if (bit_cnt > 5'd12)
			return $urandom_range(19) == 0;
		if (stk_cnt == 0 && bit_cnt < code_w)
			return $urandom_range(9) != 0;
		return $urandom_range(2) == 0;
	endfunction

	task automatic run_image();
		out_t got;
		bit ended;
		send(CMD_START, 8'($urandom), 1'b0, '0, got);
		images++;
		ended = 1'b0;
		while (!ended) begin
			if (stream_q.size() != 0 && push_next()) begin
				send(CMD_PUSH, stream_q[0], 1'b0, '0, got);
				if (got.status == ST_TAKEN)
					void'(stream_q.pop_front());
				ended = got.status == ST_ERROR;
			end else if ($urandom_range(99) < 2) begin
				send(CMD_NONE, 8'($urandom), 1'b0, '0, got);
			end else begin
				send(CMD_PULL, 8'($urandom), 1'b0, '0, got);
				ended = got.status == ST_FINISHED || got.status == ST_ERROR;
			end
			// Now and then the image is abandoned half way.
			if ($urandom_range(999) == 0)
				ended = 1'b1;
		end
	endtask

	// Short bursts of odd traffic that never make the decoder expand random data.
	task automatic noise_burst();
		out_t got;
		repeat ($urandom_range(3, 8)) begin
			case ($urandom_range(4))
				0: send(CMD_NONE, 8'($urandom), 1'b0, '0, got);
				1: begin
					if (dec_phase == PH_DECODE || dec_phase == PH_DRAIN)
						send(CMD_NONE, 8'($urandom), 1'b0, '0, got);
					else
						send(CMD_PULL, 8'($urandom), 1'b0, '0, got);
				end
				2: send(CMD_PUSH, 8'($urandom), 1'b0, '0, got);
				3: begin
					send(CMD_START, 8'($urandom), 1'b0, '0, got);
					send(CMD_PUSH, 8'($urandom), 1'b0, '0, got);
				end
				default: send(CMD_START, 8'($urandom), 1'b0, '0, got);
			endcase
		end
	endtask

	task automatic table_row(input cmd_e cmd, input logic [7:0] v, input status_e st);
		out_t fixed, got;
		fixed = '0;
		fixed.status = st;
		send(cmd, v, 1'b1, fixed, got);
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready = recv_stall == 0 || $urandom_range(99) >= recv_stall;
		end
	end

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				fails++;
				$display("%0t: result with nothing expected, status %0d", $time,
					out_data.status);
			end else begin
				want = pending_q.pop_front();
				results++;
				if (want !== out_data) begin
					fails++;
					$display("%0t: mismatch, expected st=%0d px=%0d row=%0d col=%0d bad=%0d",
						$time, want.status, want.pixel_index, want.row, want.column,
						want.bad_code_total);
					$display("%0t: mismatch, actual st=%0d px=%0d row=%0d col=%0d bad=%0d",
						$time, out_data.status, out_data.pixel_index, out_data.row,
						out_data.column, out_data.bad_code_total);
				end
			end
		end
	end

	initial begin
		#60_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int i, m, k, guard;
		clear_decoder();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed control cases with the reset configuration.
		table_row(CMD_PULL, 8'hFF, ST_FINISHED);
		table_row(CMD_PUSH, 8'hA5, ST_REFUSED);
		table_row(CMD_NONE, 8'hFF, ST_REFUSED);
		table_row(CMD_START, 8'h00, ST_STARTED);
		table_row(CMD_PULL, 8'h5A, ST_NEED);
		table_row(CMD_PUSH, 8'h01, ST_ERROR);
		table_row(CMD_START, 8'hFF, ST_STARTED);
		table_row(CMD_PUSH, 8'h0A, ST_ERROR);
		table_row(CMD_START, 8'h00, ST_STARTED);
		table_row(CMD_PUSH, 8'h02, ST_TAKEN);
		table_row(CMD_PULL, 8'h00, ST_NEED);
		table_row(CMD_PUSH, 8'h00, ST_TAKEN);
		table_row(CMD_PUSH, 8'h55, ST_REFUSED);
		table_row(CMD_PULL, 8'h00, ST_FINISHED);
		table_row(CMD_PUSH, 8'h3C, ST_REFUSED);
		table_row(CMD_START, 8'h00, ST_STARTED);
		table_row(CMD_PUSH, 8'h09, ST_TAKEN);
		table_row(CMD_PUSH, 8'h03, ST_TAKEN);
		table_row(CMD_PUSH, 8'h00, ST_TAKEN);
		table_row(CMD_PUSH, 8'hFF, ST_TAKEN);
		table_row(CMD_PUSH, 8'h12, ST_REFUSED);
		table_row(CMD_PULL, 8'h00, ST_PIXEL);
		table_row(CMD_PULL, 8'h00, ST_NEED);

		// Clear, a code equal to the next slot, a bad code, and a first code after a
		// clear that is out of range; with a height of one the second pixel overruns.
		forced_q = '{4, 1, 2, 7, 12, 4, 6, 3, 5};
		build_stream(2, 0, 1'b0);
		run_image();
		wait_idle();
		write_reg(REG_LINE_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'hFFFF);
		write_reg(REG_INTERLACED, 16'd0);
		forced_q = '{4, 1, 2, 7, 12, 4, 6, 3, 5};
		build_stream(2, 0, 1'b0);
		run_image();
		wait_idle();

		// Interlaced rows over a short image until the rows run out.
		write_reg(REG_LINE_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'd5);
		write_reg(REG_INTERLACED, 16'd1);
		forced_q.push_back(8);
		for (i = 0; i < 17; i++)
			forced_q.push_back(i % 8);
		forced_q.push_back(9);
		build_stream(3, 0, 1'b0);
		run_image();
		wait_idle();

		// Random images under each idling pattern and several configurations.
		for (m = 0; m < 4; m++) begin
			send_idle = (m == 1) ? 69 : (m == 3) ? 14 : 0;
			recv_stall = (m == 2) ? 69 : (m == 3) ? 14 : 0;
			for (k = 0; k < 2; k++) begin
				write_reg(REG_LINE_WIDTH, ($urandom_range(7) == 0) ? 16'hFFFF :
					16'($urandom_range(1, 12)));
				write_reg(REG_HEIGHT, ($urandom_range(7) == 0) ? 16'hFFFF :
					16'($urandom_range(1, 40)));
				write_reg(REG_INTERLACED, 16'($urandom_range(1)));
				if (m == 1 && k == 0)
					hold_left = 400;
				i = items;
				while (items - i < 100) begin
					if ($urandom_range(9) == 0) begin
						noise_burst();
					end else begin
						build_stream($urandom_range(2, 9), $urandom_range(3, 30),
							$urandom_range(5) == 0);
						run_image();
					end
				end
				wait_idle();
			end
		end

		in_valid = 1'b0;
		guard = 0;
		while (pending_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		if (pending_q.size() != 0) begin
			fails++;
			$display("%0t: %0d results never arrived", $time, pending_q.size());
		end
		$display("Run: %0d transactions over %0d images, %0d pixels, %0d results compared.",
			items, images, pixels, results);
		$display("Covered control errors, clears, bad codes, interlacing and stalls.");
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
